/* design/qdwtm_pkg.sv */
// ----------------------------------------------------------------------------
// qdwtm_pkg
// Shared widths, register codes and types for the depthwise tap MAC with
// requantization.
// ----------------------------------------------------------------------------
`default_nettype none

package qdwtm_pkg;

  localparam int TAPS     = 9;
  localparam int TapCntW  = (TAPS > 1) ? $clog2(TAPS) : 1;

  localparam int ByteW    = 8;
  localparam int AccW     = 32;
  localparam int MultW    = 31;
  localparam int ShiftW   = 5;
  localparam int ProdW    = AccW + MultW;     // signed acc * unsigned multiplier
  localparam int RndW     = AccW + 2;         // rounded value before the shift

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  localparam int QDepth   = 2;
  localparam int QPtrW    = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW    = $clog2(QDepth + 1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_KZP      = 3'd0,
    CFG_MULT     = 3'd1,
    CFG_SHIFT    = 3'd2,
    CFG_OZP      = 3'd3,
    CFG_CLAMP_LO = 3'd4,
    CFG_CLAMP_HI = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [ByteW-1:0]  kzp;
    logic [MultW-1:0]  mult;
    logic [ShiftW-1:0] shift;
    logic [ByteW-1:0]  ozp;
    logic [ByteW-1:0]  clamp_lo;
    logic [ByteW-1:0]  clamp_hi;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

endpackage

`default_nettype wire

/* design/quantized_depthwise_tap_mac_requant.sv */
// Path: the sum of a channel's last tap goes through the sum queue, the product
// register, the rounding register and the output register to the result port.
// Throughput: one tap per cycle, one result per TAPS taps; the front end stalls
// only on a last tap while the two-entry sum queue is full.
// Reset (synchronous, rst_n low): tap count and accumulator clear, queue and
// pipeline empty, registers return to their default values.
// ----------------------------------------------------------------------------
// quantized_depthwise_tap_mac_requant
// Depthwise tap multiply-accumulate with requantization to an output byte.
// ----------------------------------------------------------------------------
`default_nettype none

module quantized_depthwise_tap_mac_requant
  import qdwtm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output      logic                   in_stall,
  input  wire logic [ByteW-1:0]       in_pixel,
  input  wire logic [ByteW-1:0]       in_weight,
  input  wire logic signed [AccW-1:0] in_bias,
  output      logic                   out_valid,
  input  wire logic                   out_stall,
  output      logic [ByteW-1:0]       out_pixel,
  input  wire logic                   cfg_valid,
  output      logic                   cfg_ready,
  input  wire logic [CfgIdxW-1:0]     cfg_index,
  input  wire logic [CfgDataW-1:0]    cfg_data
);

  cfg_t            cfg_r;
  q_stat_t         q_stat;
  logic            q_push, q_pop;
  logic [AccW-1:0] q_in_data, q_out_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kzp      <= '0;
      cfg_r.mult     <= MultW'(32'h4000_0000);
      cfg_r.shift    <= '0;
      cfg_r.ozp      <= '0;
      cfg_r.clamp_lo <= '0;
      cfg_r.clamp_hi <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_KZP:      cfg_r.kzp      <= cfg_data[ByteW-1:0];
        CFG_MULT:     cfg_r.mult     <= cfg_data[MultW-1:0];
        CFG_SHIFT:    cfg_r.shift    <= cfg_data[ShiftW-1:0];
        CFG_OZP:      cfg_r.ozp      <= cfg_data[ByteW-1:0];
        CFG_CLAMP_LO: cfg_r.clamp_lo <= cfg_data[ByteW-1:0];
        CFG_CLAMP_HI: cfg_r.clamp_hi <= cfg_data[ByteW-1:0];
        default: ;
      endcase
    end
  end

  qdwtm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pixel  (in_pixel),
    .in_weight (in_weight),
    .in_bias   (in_bias),
    .kzp       (cfg_r.kzp),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_data    (q_in_data)
  );

  qdwtm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in_data),
    .pop       (q_pop),
    .pop_data  (q_out_data),
    .stat      (q_stat)
  );

  qdwtm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_stat    (q_stat),
    .q_data    (q_out_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pixel (out_pixel)
  );

endmodule

`default_nettype wire

/* design/qdwtm_front.sv */
// ----------------------------------------------------------------------------
// qdwtm_front
// Tap front end: takes one tap per beat, multiplies and accumulates, and
// pushes the finished channel sum into the queue on the last tap.
// ----------------------------------------------------------------------------
`default_nettype none

module qdwtm_front
  import qdwtm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output      logic                   in_stall,
  input  wire logic [ByteW-1:0]       in_pixel,
  input  wire logic [ByteW-1:0]       in_weight,
  input  wire logic signed [AccW-1:0] in_bias,
  input  wire logic [ByteW-1:0]       kzp,
  input  wire q_stat_t                q_stat,
  output      logic                   q_push,
  output      logic [AccW-1:0]        q_data
);

  logic [TapCntW-1:0]    tap_cnt_r, tap_cnt_nxt;
  logic [AccW-1:0]       acc_r, acc_nxt;
  logic                  last_tap;
  logic                  accept;
  logic signed [ByteW:0] wt_c;
  logic signed [2*ByteW+1:0] prod_c;

  assign last_tap = (tap_cnt_r == TapCntW'(TAPS - 1));

  // Only the last tap needs a queue slot; earlier taps are always taken.
  assign in_stall = q_stat.full && last_tap;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    wt_c   = $signed({1'b0, in_weight}) - $signed({1'b0, kzp});
    prod_c = $signed({1'b0, in_pixel}) * wt_c;
    if (tap_cnt_r == '0) begin
      acc_nxt = in_bias + AccW'(prod_c);
    end else begin
      acc_nxt = acc_r + AccW'(prod_c);
    end
    if (last_tap) begin
      tap_cnt_nxt = '0;
    end else begin
      tap_cnt_nxt = tap_cnt_r + 1'b1;
    end
  end

  assign q_push = accept && last_tap;
  assign q_data = acc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_cnt_r <= '0;
      acc_r     <= '0;
    end else if (accept) begin
      tap_cnt_r <= tap_cnt_nxt;
      acc_r     <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/qdwtm_queue.sv */
// ----------------------------------------------------------------------------
// qdwtm_queue
// Short register queue of channel sums between the front end and the
// requantization pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module qdwtm_queue
  import qdwtm_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire logic [AccW-1:0] push_data,
  input  wire logic            pop,
  output      logic [AccW-1:0] pop_data,
  output      q_stat_t         stat
);

  logic [AccW-1:0]  mem_r [QDepth];
  logic [QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign do_push = push && (cnt_r != QCntW'(QDepth));
  assign do_pop  = pop && (cnt_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data       = mem_r[rd_ptr_r];
  assign stat.full      = (cnt_r == QCntW'(QDepth));
  assign stat.not_empty = (cnt_r != '0);

endmodule

`default_nettype wire

/* design/qdwtm_back.sv */
// ----------------------------------------------------------------------------
// qdwtm_back
// Requantization pipeline: high multiply, rounding shift, saturation,
// zero point and clamp, with an output register toward the result port.
// ----------------------------------------------------------------------------
`default_nettype none

module qdwtm_back
  import qdwtm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_t             cfg,
  input  wire q_stat_t          q_stat,
  input  wire logic [AccW-1:0]  q_data,
  output      logic             q_pop,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      logic [ByteW-1:0] out_pixel
);

  logic                    a_vld_r;
  logic signed [ProdW-1:0] prod_r;
  logic                    b_vld_r;
  logic signed [RndW-1:0]  rnd_r;
  logic                    out_valid_r;
  logic [ByteW-1:0]        out_pixel_r;

  logic out_free, b_free, a_free;

  logic signed [2*AccW-1:0] prod_full;
  logic signed [2*AccW-1:0] dbl_c;
  logic signed [AccW-1:0]   hi_c;
  logic signed [AccW:0]     dec_c;
  logic signed [RndW-1:0]   half_c;
  logic signed [RndW-1:0]   rnd_nxt;

  logic signed [RndW-1:0]   sh_c;
  logic signed [15:0]       s16_c;
  logic signed [16:0]       zp_sum_c;
  logic signed [15:0]       zp_sat_c;
  logic [ByteW-1:0]         byte_c;
  logic [ByteW-1:0]         pix_nxt;

  assign out_free = !out_valid_r || !out_stall;
  assign b_free   = !b_vld_r || out_free;
  assign a_free   = !a_vld_r || b_free;
  assign q_pop    = q_stat.not_empty && a_free;

  // Stage A: signed sum times the non-negative Q31 multiplier.
  assign prod_full = $signed(q_data) * $signed({1'b0, cfg.mult});

  // Stage B: doubling, rounding into the high word, and the pre-shift rounding.
  always_comb begin
    dbl_c  = {prod_r, 1'b0} + $signed(64'h0000_0000_8000_0000);
    hi_c   = dbl_c[2*AccW-1:AccW];
    dec_c  = {hi_c[AccW-1], hi_c};
    half_c = '0;
    if (cfg.shift != '0) begin
      if (hi_c < 0) begin
        dec_c = dec_c - 1'b1;
      end
      half_c = $signed(RndW'(1) << (cfg.shift - 1'b1));
    end
    rnd_nxt = $signed({dec_c[AccW], dec_c}) + half_c;
  end

  // Stage C: arithmetic shift floors; then the chain of saturations and clamps.
  always_comb begin
    sh_c = rnd_r >>> cfg.shift;
    if (sh_c < -32768) begin
      s16_c = 16'sh8000;
    end else if (sh_c > 32767) begin
      s16_c = 16'sh7FFF;
    end else begin
      s16_c = sh_c[15:0];
    end
    zp_sum_c = $signed({s16_c[15], s16_c}) + $signed({9'b0, cfg.ozp});
    if (zp_sum_c > 32767) begin
      zp_sat_c = 16'sh7FFF;
    end else begin
      zp_sat_c = zp_sum_c[15:0];
    end
    if (zp_sat_c < 0) begin
      byte_c = '0;
    end else if (zp_sat_c > 255) begin
      byte_c = '1;
    end else begin
      byte_c = zp_sat_c[ByteW-1:0];
    end
    pix_nxt = byte_c;
    if (pix_nxt < cfg.clamp_lo) begin
      pix_nxt = cfg.clamp_lo;
    end
    if (pix_nxt > cfg.clamp_hi) begin
      pix_nxt = cfg.clamp_hi;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r     <= 1'b0;
      b_vld_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (a_free) begin
        a_vld_r <= q_pop;
      end
      if (b_free) begin
        b_vld_r <= a_vld_r;
      end
      if (out_free) begin
        out_valid_r <= b_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      prod_r <= prod_full[ProdW-1:0];
    end
    if (a_vld_r && b_free) begin
      rnd_r <= rnd_nxt;
    end
    if (b_vld_r && out_free) begin
      out_pixel_r <= pix_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;

endmodule

`default_nettype wire

/* design/qdwtm_checker.sv */
// ----------------------------------------------------------------------------
// qdwtm_checker
// Port-level checks: taps per result, front-end stall rule, output hold, write taken.
// ----------------------------------------------------------------------------
`default_nettype none

module qdwtm_checker
  import qdwtm_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_stall,
  input wire logic                   out_valid,
  input wire logic                   out_stall,
  input wire logic [ByteW-1:0]       out_pixel,
  input wire logic                   cfg_valid,
  input wire logic                   cfg_ready
);

  localparam int PendW = 3;

  logic [TapCntW-1:0] chk_tap_r;
  logic [PendW-1:0]   pend_r;
  logic               in_beat, out_beat, grp_done;

  assign in_beat  = in_valid && !in_stall;
  assign out_beat = out_valid && !out_stall;
  assign grp_done = in_beat && (chk_tap_r == TapCntW'(TAPS - 1));

  // Channels whose last tap went in but whose result has not yet come out.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_tap_r <= '0;
      pend_r    <= '0;
    end else begin
      if (in_beat) begin
        chk_tap_r <= grp_done ? '0 : chk_tap_r + 1'b1;
      end
      pend_r <= pend_r + PendW'(grp_done) - PendW'(out_beat);
    end
  end

  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat |-> pend_r != '0)
    else $error("result beat without a completed channel");

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= PendW'(QDepth + 3))
    else $error("more channels in flight than the queue and pipeline hold");

  a_mid_tap_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && chk_tap_r != TapCntW'(TAPS - 1)) |-> !in_stall)
    else $error("front end stalled a tap that is not the last of a channel");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_pixel)))
    else $error("stalled result changed or dropped");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("register write was not taken");

endmodule

bind quantized_depthwise_tap_mac_requant qdwtm_checker u_qdwtm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_pixel (out_pixel),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

`default_nettype wire

/* tb/tb_quantized_depthwise_tap_mac_requant.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quantized_depthwise_tap_mac_requant
// Self-checking bench for the depthwise tap MAC. Taps are fed from a queue
// under random sender and receiver idling. Each accepted tap is folded into a
// local accumulator. Every completed group is requantized locally and the byte
// is compared with the block's result beat. The register set is rewritten
// between phases, always with the block idle.
// ----------------------------------------------------------------------------
module tb_quantized_depthwise_tap_mac_requant;
  import qdwtm_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_IDX_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_IDX_SPARE_HI = 3'd7;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [ByteW-1:0] pixel;
    logic [ByteW-1:0] weight;
    logic [AccW-1:0]  bias;
  } tap_beat_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [ByteW-1:0]       in_pixel = '0;
  logic [ByteW-1:0]       in_weight = '0;
  logic signed [AccW-1:0] in_bias = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [ByteW-1:0]       out_pixel;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CfgIdxW-1:0]     cfg_index = CFG_KZP;
  logic [CfgDataW-1:0]    cfg_data = '0;

  tap_beat_t        tap_queue[$];
  logic [ByteW-1:0] expected_bytes[$];
  cfg_t             shadow_cfg;
  logic [AccW-1:0]  acc_sum;
  int               taps_taken;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  logic             hold_start = 1'b0;
  int               hold_left = 0;
  int               error_count = 0;

  quantized_depthwise_tap_mac_requant u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_pixel  (in_pixel),
    .in_weight (in_weight),
    .in_bias   (in_bias),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pixel (out_pixel),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    error_count++;
  endtask

  function automatic logic [ByteW-1:0] requantize_sum(input logic [AccW-1:0] sum);
    longint a;
    longint m;
    longint v;
    int     s;
    a = longint'(signed'(sum));
    m = longint'(shadow_cfg.mult);
    // Arithmetic shifts on a 64-bit signed value give the floor division.
    v = (2 * a * m + (longint'(1) <<< 31)) >>> 32;
    s = int'(shadow_cfg.shift);
    if (s != 0) begin
      if (v < 0) v = v - 1;
      v = (v + (longint'(1) <<< (s - 1))) >>> s;
    end
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    v = v + longint'(shadow_cfg.ozp);
    if (v > 32767) v = 32767;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    // The upper bound goes last, so crossed bounds give clamp_hi.
    if (v < longint'(shadow_cfg.clamp_lo)) v = longint'(shadow_cfg.clamp_lo);
    if (v > longint'(shadow_cfg.clamp_hi)) v = longint'(shadow_cfg.clamp_hi);
    return v[ByteW-1:0];
  endfunction

  function automatic void accumulate_tap(input tap_beat_t beat);
    int prod;
    prod = int'(beat.pixel) * (int'(beat.weight) - int'(shadow_cfg.kzp));
    if (taps_taken == 0) acc_sum = beat.bias + AccW'(prod);
    else acc_sum = acc_sum + AccW'(prod);
    taps_taken++;
    if (taps_taken >= TAPS) begin
      taps_taken = 0;
      expected_bytes.push_back(requantize_sum(acc_sum));
    end
  endfunction

  // Tap driver: a stalled beat is held, otherwise the next one may be offered.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      acc_sum    = '0;
      taps_taken = 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        accumulate_tap(tap_queue[0]);
        void'(tap_queue.pop_front());
      end
      if (tap_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid  <= 1'b1;
        in_pixel  <= tap_queue[0].pixel;
        in_weight <= tap_queue[0].weight;
        in_bias   <= tap_queue[0].bias;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) hold_left <= 0;
    else if (hold_start) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("result beat %0d with nothing expected", out_pixel));
        end else begin
          if (out_pixel !== expected_bytes[0])
            report_mismatch($sformatf("out_pixel got %0d, expected %0d",
                                      out_pixel, expected_bytes[0]));
          void'(expected_bytes.pop_front());
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic push_tap(input logic [ByteW-1:0] pixel, input logic [ByteW-1:0] weight,
                          input logic [AccW-1:0] bias);
    tap_beat_t beat;
    beat.pixel  = pixel;
    beat.weight = weight;
    beat.bias   = bias;
    tap_queue.push_back(beat);
  endtask

  task automatic push_random_taps(input int count);
    logic [ByteW-1:0] pixel;
    logic [ByteW-1:0] weight;
    logic [AccW-1:0]  bias;
    for (int k = 0; k < count; k++) begin
      pixel  = $urandom_range(7) == 0 ? {ByteW{$urandom_range(1) == 1}} : ByteW'($urandom());
      weight = $urandom_range(7) == 0 ? {ByteW{$urandom_range(1) == 1}} : ByteW'($urandom());
      // Mostly small biases, so that sums land inside the output range.
      if ($urandom_range(2) == 0) bias = $urandom();
      else bias = AccW'(int'($urandom_range(4000)) - 2000);
      push_tap(pixel, weight, bias);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (tap_queue.size() != 0 || in_valid || expected_bytes.size() != 0);
    // A partial group may still be in the MAC when the last result leaves.
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_t                next_cfg;
    logic [CfgDataW-1:0] data;
    next_cfg = shadow_cfg;
    // Bits above the field are random and must be dropped by the block.
    data = $urandom();
    case (idx)
      CFG_KZP: begin
        data[ByteW-1:0] = value[ByteW-1:0];
        next_cfg.kzp    = value[ByteW-1:0];
      end
      CFG_MULT: begin
        data[MultW-1:0] = value[MultW-1:0];
        next_cfg.mult   = value[MultW-1:0];
      end
      CFG_SHIFT: begin
        data[ShiftW-1:0] = value[ShiftW-1:0];
        next_cfg.shift   = value[ShiftW-1:0];
      end
      CFG_OZP: begin
        data[ByteW-1:0] = value[ByteW-1:0];
        next_cfg.ozp    = value[ByteW-1:0];
      end
      CFG_CLAMP_LO: begin
        data[ByteW-1:0]   = value[ByteW-1:0];
        next_cfg.clamp_lo = value[ByteW-1:0];
      end
      CFG_CLAMP_HI: begin
        data[ByteW-1:0]   = value[ByteW-1:0];
        next_cfg.clamp_hi = value[ByteW-1:0];
      end
      default: ;
    endcase
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk);
    while (!cfg_ready);
    shadow_cfg = next_cfg;
    cfg_valid <= 1'b0;
  endtask

  task automatic write_cfg(input cfg_t c);
    write_reg(CFG_KZP, CfgDataW'(c.kzp));
    write_reg(CFG_MULT, CfgDataW'(c.mult));
    write_reg(CFG_SHIFT, CfgDataW'(c.shift));
    write_reg(CFG_OZP, CfgDataW'(c.ozp));
    write_reg(CFG_CLAMP_LO, CfgDataW'(c.clamp_lo));
    write_reg(CFG_CLAMP_HI, CfgDataW'(c.clamp_hi));
  endtask

  function automatic cfg_t random_cfg(input int phase);
    cfg_t c;
    c.kzp      = ByteW'($urandom());
    c.mult     = $urandom_range(3) == 0 ? MultW'($urandom())
                                         : MultW'($urandom_range(32'h7FFF_FFFF, 32'h2000_0000));
    c.shift    = $urandom_range(3) == 0 ? ShiftW'($urandom()) : ShiftW'($urandom_range(14, 4));
    c.ozp      = ByteW'($urandom());
    c.clamp_lo = ByteW'($urandom_range(60));
    c.clamp_hi = ByteW'($urandom_range(255, 180));
    case (phase)
      0: begin
        c.kzp = 8'hFF; c.mult = 31'h7FFF_FFFF; c.shift = 5'd31;
        c.ozp = 8'hFF; c.clamp_lo = 8'h00; c.clamp_hi = 8'hFF;
      end
      1: begin
        c.kzp = 8'h00; c.mult = '0; c.shift = 5'd0;
        c.ozp = 8'h00; c.clamp_lo = 8'h00; c.clamp_hi = 8'hFF;
      end
      2: begin
        // Crossed bounds: the low bound sits above the high one.
        c.clamp_lo = ByteW'($urandom_range(255, 129));
        c.clamp_hi = ByteW'($urandom_range(128));
      end
      default: ;
    endcase
    return c;
  endfunction

  initial begin
    cfg_t extreme_cfg;
    shadow_cfg.kzp      = 8'h00;
    shadow_cfg.mult     = 31'h4000_0000;
    shadow_cfg.shift    = 5'd0;
    shadow_cfg.ozp      = 8'h00;
    shadow_cfg.clamp_lo = 8'h00;
    shadow_cfg.clamp_hi = 8'hFF;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 23;
    recv_idle_pct = 73;

    // Default registers: a group that wraps the accumulator past the top,
    // then one that lands exactly on 255. Biases after the first tap are noise.
    for (int k = 0; k < TAPS; k++)
      push_tap(8'hFF, 8'hFF, k == 0 ? 32'h7FFF_FFFF : $urandom());
    for (int k = 0; k < TAPS; k++)
      push_tap(8'h00, 8'hFF, k == 0 ? 32'd510 : $urandom());
    wait_idle();

    // Largest zero points and multiplier; writes to unused indexes are no-ops.
    extreme_cfg.kzp      = 8'hFF;
    extreme_cfg.mult     = 31'h7FFF_FFFF;
    extreme_cfg.shift    = 5'd1;
    extreme_cfg.ozp      = 8'hFF;
    extreme_cfg.clamp_lo = 8'h00;
    extreme_cfg.clamp_hi = 8'hFF;
    write_cfg(extreme_cfg);
    write_reg(CFG_IDX_SPARE_LO, $urandom());
    write_reg(CFG_IDX_SPARE_HI, $urandom());
    for (int k = 0; k < TAPS; k++)
      push_tap(8'hFF, 8'h00, k == 0 ? 32'h8000_0000 : $urandom());

    for (int phase = 0; phase < 9; phase++) begin
      wait_idle();
      if (phase == 3) begin
        send_idle_pct = 73;
        recv_idle_pct = 23;
      end else if (phase == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_cfg(random_cfg(phase));
      push_random_taps(36);
    end
    wait_idle();

    // Hold the result side off for a long stretch while taps keep coming,
    // so the sum queue fills and the input side has to stall.
    @(posedge clk);
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    push_random_taps(90);
    wait_idle();

    if (expected_bytes.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived", expected_bytes.size()));
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* sim.f */
design/qdwtm_pkg.sv
design/qdwtm_front.sv
design/qdwtm_queue.sv
design/qdwtm_back.sv
design/quantized_depthwise_tap_mac_requant.sv
design/qdwtm_checker.sv
tb/tb_quantized_depthwise_tap_mac_requant.sv
